// ===== src/dlce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlce_pkg
// Shared types and codes of the doubly linked list cursor engine: the request
// and response words, operation and status codes and the sequencer states.
// ----------------------------------------------------------------------------
package dlce_pkg;

   // Default sizes of the node pool.
   localparam int CAPACITY_DEFAULT    = 256;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Operation codes carried in the kind field.
   localparam logic [4:0] KIND_CLEAR        = 5'd0;
   localparam logic [4:0] KIND_INSERT_FIRST = 5'd1;
   localparam logic [4:0] KIND_INSERT_LAST  = 5'd2;
   localparam logic [4:0] KIND_CURSOR_FIRST = 5'd3;
   localparam logic [4:0] KIND_CURSOR_LAST  = 5'd4;
   localparam logic [4:0] KIND_READ_FIRST   = 5'd5;
   localparam logic [4:0] KIND_READ_LAST    = 5'd6;
   localparam logic [4:0] KIND_DELETE_FIRST = 5'd7;
   localparam logic [4:0] KIND_DELETE_LAST  = 5'd8;
   localparam logic [4:0] KIND_DELETE_AFTER = 5'd9;
   localparam logic [4:0] KIND_DELETE_BEFORE = 5'd10;
   localparam logic [4:0] KIND_INSERT_AFTER = 5'd11;
   localparam logic [4:0] KIND_INSERT_BEFORE = 5'd12;
   localparam logic [4:0] KIND_READ_CURSOR  = 5'd13;
   localparam logic [4:0] KIND_WRITE_CURSOR = 5'd14;
   localparam logic [4:0] KIND_CURSOR_NEXT  = 5'd15;
   localparam logic [4:0] KIND_CURSOR_PREV  = 5'd16;

   // Status codes of a response.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_NO_CURSOR = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic [4:0]         kind;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic               cursor_active;
      logic [8:0]         element_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ1,
      ST_READ2,
      ST_WRITE1,
      ST_WRITE2,
      ST_HOLD
   } state_type;

endpackage

// ===== src/doubly_linked_list_cursor_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_list_cursor_engine
// Doubly linked list with a cursor over a pool of nodes kept in three
// synchronous memories (value, next link, previous link).
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid, req_stall | req_data  (req_type)
//   rsp     | out       | rsp_valid, rsp_stall | rsp_data  (rsp_type)
//
// A word is accepted only while the sequencer is idle. It then passes through
// READ1, READ2, WRITE1 and WRITE2: two dependent link reads and two writes on
// the link memories; no new word is accepted until it is back in ST_IDLE.
// The response is registered; the next word is accepted while it waits.
// Reset empties the list at once: unused nodes are handed out in index order
// from a fill mark, freed nodes go on a free chain, so no clearing pass runs.
// A stalled response holds the sequencer in its last state.
// ----------------------------------------------------------------------------
module doubly_linked_list_cursor_engine
   import dlce_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // Node memories.
   logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];
   logic [IW-1:0]          next_mem  [CAPACITY];
   logic [IW-1:0]          prev_mem  [CAPACITY];

   // Sequencer and list registers.
   state_type state_ff, state_in;
   logic [4:0]             kind_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic          cv_ff, cv_in;
   logic [CW-1:0] count_ff, count_in, mark_ff, mark_in;
   logic [IW-1:0] free_ff, free_in;
   logic [IW-1:0] n1_ff, p1_ff;
   rsp_type       res_ff, res_in;

   // Deferred second writes to the link memories.
   logic          w2n_en_ff, w2n_en_in, w2p_en_ff, w2p_en_in;
   logic [IW-1:0] w2n_addr_ff, w2n_addr_in, w2n_data_ff, w2n_data_in;
   logic [IW-1:0] w2p_addr_ff, w2p_addr_in, w2p_data_ff, w2p_data_in;

   // Memory read data registers.
   logic [IW-1:0]          nrd_ff, prd_ff;
   logic [VALUE_WIDTH-1:0] vrd_ff;

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // Memory port controls.
   logic          n_re, p_re, v_re, n_we, p_we, v_we;
   logic [IW-1:0] n_raddr, p_raddr, v_raddr, n_waddr, p_waddr, v_waddr;
   logic [IW-1:0] n_wdata, p_wdata;
   logic [VALUE_WIDTH-1:0] v_wdata;

   // First-write controls from the operation logic.
   logic          wn_en, wp_en, wv_en;
   logic [IW-1:0] wn_addr, wn_data, wp_addr, wp_data, wv_addr;

   logic accept, out_free, rsp_load;
   logic [63:0] value_ext, read_ext;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign value_ext = {{32{req_data.value[31]}}, req_data.value};
   assign read_ext  = 64'(vrd_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_READ1;
         ST_READ1:  state_in = ST_READ2;
         ST_READ2:  state_in = ST_WRITE1;
         ST_WRITE1: state_in = ST_WRITE2;
         ST_WRITE2: state_in = out_free ? ST_IDLE : ST_HOLD;
         ST_HOLD:   state_in = out_free ? ST_IDLE : ST_HOLD;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshake, memory addresses and enables.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_load  = (state_ff == ST_WRITE2 || state_ff == ST_HOLD) && out_free;
      n_re = 1'b0;
      p_re = 1'b0;
      v_re = 1'b0;
      n_raddr = free_ff;
      p_raddr = cur_ff;
      v_raddr = cur_ff;
      n_we = 1'b0;
      p_we = 1'b0;
      v_we = 1'b0;
      n_waddr = wn_addr;
      n_wdata = wn_data;
      p_waddr = wp_addr;
      p_wdata = wp_data;
      v_waddr = wv_addr;
      v_wdata = value_ff;
      case (state_ff)
         ST_READ1: begin
            n_re = 1'b1;
            p_re = 1'b1;
            v_re = 1'b1;
            case (kind_ff)
               KIND_DELETE_FIRST: n_raddr = head_ff;
               KIND_DELETE_AFTER, KIND_INSERT_AFTER, KIND_CURSOR_NEXT: n_raddr = cur_ff;
               default: n_raddr = free_ff;
            endcase
            p_raddr = (kind_ff == KIND_DELETE_LAST) ? tail_ff : cur_ff;
            case (kind_ff)
               KIND_READ_FIRST: v_raddr = head_ff;
               KIND_READ_LAST:  v_raddr = tail_ff;
               default:         v_raddr = cur_ff;
            endcase
         end
         ST_READ2: begin
            // Second, dependent reads follow the first link.
            n_re    = 1'b1;
            p_re    = 1'b1;
            n_raddr = (kind_ff == KIND_DELETE_AFTER) ? nrd_ff : free_ff;
            p_raddr = prd_ff;
         end
         ST_WRITE1: begin
            n_we = wn_en;
            p_we = wp_en;
            v_we = wv_en;
         end
         ST_WRITE2: begin
            n_we    = w2n_en_ff;
            n_waddr = w2n_addr_ff;
            n_wdata = w2n_data_ff;
            p_we    = w2p_en_ff;
            p_waddr = w2p_addr_ff;
            p_wdata = w2p_data_ff;
         end
         default: ;
      endcase
   end

   // Operation logic, evaluated in the first write cycle.
   always_comb begin
      logic          has, full, from_chain;
      logic [IW-1:0] alloc_n, alloc_next, d;
      has        = (count_ff != '0);
      full       = (count_ff == CW'(CAPACITY));
      from_chain = (mark_ff != count_ff);
      alloc_n    = from_chain ? free_ff : mark_ff[IW-1:0];
      alloc_next = (kind_ff == KIND_INSERT_AFTER) ? nrd_ff : n1_ff;
      d          = n1_ff;

      head_in  = head_ff;
      tail_in  = tail_ff;
      cur_in   = cur_ff;
      cv_in    = cv_ff;
      count_in = count_ff;
      mark_in  = mark_ff;
      free_in  = free_ff;
      wn_en = 1'b0;  wn_addr = alloc_n;  wn_data = head_ff;
      wp_en = 1'b0;  wp_addr = alloc_n;  wp_data = alloc_n;
      wv_en = 1'b0;  wv_addr = alloc_n;
      w2n_en_in = 1'b0;  w2n_addr_in = alloc_n;  w2n_data_in = alloc_n;
      w2p_en_in = 1'b0;  w2p_addr_in = alloc_n;  w2p_data_in = alloc_n;
      res_in.read_value = '0;
      res_in.status     = STATUS_OK;

      case (kind_ff)
         KIND_CLEAR: begin
            head_in  = '0;
            tail_in  = '0;
            cur_in   = '0;
            cv_in    = 1'b0;
            count_in = '0;
            mark_in  = '0;
            free_in  = '0;
         end
         KIND_INSERT_FIRST, KIND_INSERT_LAST, KIND_INSERT_AFTER, KIND_INSERT_BEFORE: begin
            if ((kind_ff == KIND_INSERT_AFTER || kind_ff == KIND_INSERT_BEFORE) && !cv_ff) begin
               // Insert at the cursor without a cursor does nothing.
            end else if (full) begin
               res_in.status = STATUS_FULL;
            end else begin
               // Take a node: from the free chain, else the next unused one.
               count_in = count_ff + 1'b1;
               if (from_chain) free_in = alloc_next;
               else mark_in = mark_ff + 1'b1;
               wv_en = 1'b1;
               case (kind_ff)
                  KIND_INSERT_FIRST: begin
                     wn_en   = 1'b1;
                     wn_data = head_ff;
                     wp_en   = has;
                     wp_addr = head_ff;
                     head_in = alloc_n;
                     if (!has) tail_in = alloc_n;
                  end
                  KIND_INSERT_LAST: begin
                     wn_en   = has;
                     wn_addr = tail_ff;
                     wn_data = alloc_n;
                     wp_en   = 1'b1;
                     wp_data = tail_ff;
                     tail_in = alloc_n;
                     if (!has) head_in = alloc_n;
                  end
                  KIND_INSERT_AFTER: begin
                     wn_en   = 1'b1;
                     wn_addr = cur_ff;
                     wn_data = alloc_n;
                     wp_en   = 1'b1;
                     wp_data = cur_ff;
                     if (cur_ff == tail_ff) begin
                        tail_in = alloc_n;
                     end else begin
                        w2n_en_in   = 1'b1;
                        w2n_data_in = n1_ff;
                        w2p_en_in   = 1'b1;
                        w2p_addr_in = n1_ff;
                     end
                  end
                  default: begin
                     // Insert before the cursor.
                     wn_en   = 1'b1;
                     wn_data = cur_ff;
                     wp_en   = 1'b1;
                     wp_addr = cur_ff;
                     if (cur_ff == head_ff) begin
                        head_in = alloc_n;
                     end else begin
                        w2p_en_in   = 1'b1;
                        w2p_data_in = p1_ff;
                        w2n_en_in   = 1'b1;
                        w2n_addr_in = p1_ff;
                     end
                  end
               endcase
            end
         end
         KIND_CURSOR_FIRST: begin
            cur_in = head_ff;
            cv_in  = has;
         end
         KIND_CURSOR_LAST: begin
            cur_in = tail_ff;
            cv_in  = has;
         end
         KIND_READ_FIRST, KIND_READ_LAST: begin
            if (has) res_in.read_value = read_ext[31:0];
            else res_in.status = STATUS_EMPTY;
         end
         KIND_READ_CURSOR: begin
            if (cv_ff) res_in.read_value = read_ext[31:0];
            else res_in.status = STATUS_NO_CURSOR;
         end
         KIND_WRITE_CURSOR: begin
            wv_en   = cv_ff;
            wv_addr = cur_ff;
         end
         KIND_DELETE_FIRST, KIND_DELETE_LAST: begin
            if (has) begin
               d = (kind_ff == KIND_DELETE_FIRST) ? head_ff : tail_ff;
               if (cv_ff && cur_ff == d) cv_in = 1'b0;
               if (count_ff == CW'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (kind_ff == KIND_DELETE_FIRST) begin
                  head_in = n1_ff;
               end else begin
                  tail_in = p1_ff;
               end
               // Return the node to the free chain.
               wn_en    = 1'b1;
               wn_addr  = d;
               wn_data  = free_ff;
               free_in  = d;
               count_in = count_ff - 1'b1;
            end
         end
         KIND_DELETE_AFTER: begin
            if (cv_ff && cur_ff != tail_ff) begin
               d = n1_ff;
               if (d == tail_ff) begin
                  tail_in = cur_ff;
               end else begin
                  wn_en   = 1'b1;
                  wn_addr = cur_ff;
                  wn_data = nrd_ff;
                  wp_en   = 1'b1;
                  wp_addr = nrd_ff;
                  wp_data = cur_ff;
               end
               w2n_en_in   = 1'b1;
               w2n_addr_in = d;
               w2n_data_in = free_ff;
               free_in     = d;
               count_in    = count_ff - 1'b1;
            end
         end
         KIND_DELETE_BEFORE: begin
            if (cv_ff && cur_ff != head_ff) begin
               d = p1_ff;
               if (d == head_ff) begin
                  head_in = cur_ff;
               end else begin
                  wp_en   = 1'b1;
                  wp_addr = cur_ff;
                  wp_data = prd_ff;
                  wn_en   = 1'b1;
                  wn_addr = prd_ff;
                  wn_data = cur_ff;
               end
               w2n_en_in   = 1'b1;
               w2n_addr_in = d;
               w2n_data_in = free_ff;
               free_in     = d;
               count_in    = count_ff - 1'b1;
            end
         end
         KIND_CURSOR_NEXT: begin
            if (cv_ff) begin
               if (cur_ff == tail_ff) cv_in = 1'b0;
               else cur_in = n1_ff;
            end
         end
         KIND_CURSOR_PREV: begin
            if (cv_ff) begin
               if (cur_ff == head_ff) cv_in = 1'b0;
               else cur_in = p1_ff;
            end
         end
         default: ;
      endcase

      res_in.cursor_active = cv_in;
      res_in.element_count = 9'(count_in);
   end

   // Node memories: one read and one write port each, registered read data.
   always_ff @(posedge clock) begin
      if (n_we) next_mem[n_waddr] <= n_wdata;
      if (n_re) nrd_ff <= next_mem[n_raddr];
   end

   always_ff @(posedge clock) begin
      if (p_we) prev_mem[p_waddr] <= p_wdata;
      if (p_re) prd_ff <= prev_mem[p_raddr];
   end

   always_ff @(posedge clock) begin
      if (v_we) value_mem[v_waddr] <= v_wdata;
      if (v_re) vrd_ff <= value_mem[v_raddr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         cur_ff       <= '0;
         cv_ff        <= 1'b0;
         count_ff     <= '0;
         mark_ff      <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_WRITE1) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            cur_ff   <= cur_in;
            cv_ff    <= cv_in;
            count_ff <= count_in;
            mark_ff  <= mark_in;
            free_ff  <= free_in;
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_data.kind;
         value_ff <= value_ext[VALUE_WIDTH-1:0];
      end
      if (state_ff == ST_READ2) begin
         n1_ff <= nrd_ff;
         p1_ff <= prd_ff;
      end
      if (state_ff == ST_WRITE1) begin
         res_ff      <= res_in;
         w2n_en_ff   <= w2n_en_in;
         w2n_addr_ff <= w2n_addr_in;
         w2n_data_ff <= w2n_data_in;
         w2p_en_ff   <= w2p_en_in;
         w2p_addr_ff <= w2p_addr_in;
         w2p_data_ff <= w2p_data_in;
      end
      if (rsp_load) rsp_data_ff <= res_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/dlce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlce_checker
// Port-level checks of the doubly linked list cursor engine, bound to the top
// level.
// ----------------------------------------------------------------------------
module dlce_checker
   import dlce_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled response word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   // The engine works on one word at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("word accepted while busy");

   // An empty read leaves an empty list.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_EMPTY |-> rsp_data.element_count == 9'd0)
      else $error("empty status with nonzero count");

   // A failed cursor read reports no cursor.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_NO_CURSOR |-> !rsp_data.cursor_active)
      else $error("no-cursor status with active cursor");

   // A full pool shows the whole capacity in use.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_FULL |->
         rsp_data.element_count == 9'(CAPACITY))
      else $error("full status below capacity");

endmodule

bind doubly_linked_list_cursor_engine dlce_checker #(.CAPACITY(CAPACITY)) u_dlce_checker (.*);
